// File: hw/rtl/rbv_pkg.sv
// shared types, codes and the crc32c byte update for the record block validator
// no dependencies
package rbv_pkg;

	localparam logic [31:0] BLK_MAGIC = 32'h314b_4c42;
	localparam logic [31:0] CRC_POLY  = 32'h82f6_3b78;
	localparam logic [40:0] POS_CAP   = 41'h100_0000_0000;

	localparam logic OP_DESC = 1'b0;
	localparam logic OP_BYTE = 1'b1;

	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic CFG_ANCHOR_LIMIT     = 1'b0;
	localparam logic CFG_RESTART_INTERVAL = 1'b1;

	localparam logic [3:0] ST_OK       = 4'd0;
	localparam logic [3:0] ST_SIZE     = 4'd1;
	localparam logic [3:0] ST_CRC      = 4'd2;
	localparam logic [3:0] ST_HEADER   = 4'd3;
	localparam logic [3:0] ST_RCOUNT   = 4'd4;
	localparam logic [3:0] ST_LENGTHS  = 4'd5;
	localparam logic [3:0] ST_RTRUNC   = 4'd6;
	localparam logic [3:0] ST_RMISMAT  = 4'd7;
	localparam logic [3:0] ST_SPAN     = 4'd8;
	localparam logic [3:0] ST_CAPACITY = 4'd9;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_LENGTHS,
		PH_RESTARTS,
		PH_PAYLOAD,
		PH_DRAIN
	} phase_t;

	typedef struct packed {
		logic        op;
		logic [7:0]  data_byte;
		logic        last_byte;
		logic [39:0] expected_byte_count;
		logic [31:0] expected_crc;
		logic [31:0] expected_first_record;
		logic [15:0] expected_record_count;
	} item_t;

	typedef struct packed {
		logic        kind;
		logic [15:0] record_number;
		logic [39:0] record_start;
		logic [3:0]  status;
		logic [31:0] payload_bytes;
		logic [31:0] first_record;
		logic [15:0] anchor_count;
		logic        end_flag;
	} result_t;

	function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'd0, b};
		for (int i = 0; i < 8; i++) begin
			c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'd0);
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/rbv_prefix_ram.sv
// restart prefix store: one write port, one registered read port
// no dependencies
module rbv_prefix_ram #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [39:0]   wdata,
	input  logic [AW-1:0] raddr,
	output logic [39:0]   rdata
);

	logic [39:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// File: hw/rtl/record_block_validator.sv
// record block validator top level: crc32c, header/length/restart parser, status
// depends on rbv_pkg and rbv_prefix_ram
//
// A descriptor transaction opens a block; each following byte transaction is
// checksummed and parsed. A byte that causes no result is taken every cycle
// while the output slots are empty or their last result is being taken. A
// byte that yields a record start and/or the final status holds them in two
// output slots and sends them one per cycle while the sink is ready; the next
// item is taken in the cycle its last result is taken. Restart prefixes live in
// a MAX_RESTARTS x 40 memory with a registered read, read ahead while the four
// bytes of each table entry arrive. The store needs no clearing after reset.
// Configuration writes are always ready and must be made while the block is idle.
module record_block_validator #(
	parameter int MAX_RESTARTS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  rbv_pkg::item_t    item,
	output logic              result_valid,
	input  logic              result_ready,
	output rbv_pkg::result_t  result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data
);

	localparam int AW = (MAX_RESTARTS > 1) ? $clog2(MAX_RESTARTS) : 1;

	rbv_pkg::phase_t  phase_q, phase_n;
	logic [40:0]      pos_q, pos_n;
	logic [31:0]      crc_q, crc_n;
	logic [7:0]       hdr_q [16];
	logic [7:0]       hv [16];
	logic [39:0]      exp_cnt_q;
	logic [31:0]      exp_crc_q;
	logic [31:0]      exp_first_q;
	logic [15:0]      exp_rec_q;
	logic [15:0]      len_q, len_n;
	logic [1:0]       sub_q, sub_n;
	logic [15:0]      rec_cnt_q, rec_cnt_n;
	logic [39:0]      sum_q, sum_n;
	logic [15:0]      rd_idx_q, rd_idx_n;
	logic [3:0]       err_q, err_n;
	logic [23:0]      ent_q, ent_n;
	logic             mis_q, mis_n;
	logic             hdr_full_q, hdr_full_n;
	logic [15:0]      grp_q, grp_n;
	logic [15:0]      wr_idx_q, wr_idx_n;
	logic [40:0]      te_q, te_n;
	logic [8:0]       anch_q;
	logic [15:0]      intv_q;
	rbv_pkg::result_t slot0_q, slot1_q, rec_res, st_res;
	logic             v0_q, v1_q, emit_rec, emit_st;

	logic             take, take_byte, pop;
	logic [7:0]       b;
	logic [15:0]      f_vc, f_an, f_rvc, f_rc, amin, grp_inc;
	logic [31:0]      f_first, rc_prod;
	logic [32:0]      rc_hi;
	logic [23:0]      len_full;
	logic [31:0]      ent_full;
	logic [40:0]      got;
	logic [3:0]       st;
	logic             mem_we;
	logic [39:0]      mem_rdata;

	assign cfg_ready    = 1'b1;
	assign item_ready   = (!v0_q && !v1_q) || (result_ready && (v0_q ^ v1_q));
	assign take         = item_valid && item_ready;
	assign take_byte    = take && item.op == rbv_pkg::OP_BYTE && phase_q != rbv_pkg::PH_IDLE;
	assign b            = item.data_byte;
	assign result_valid = v0_q || v1_q;
	assign result       = v0_q ? slot0_q : slot1_q;
	assign pop          = result_valid && result_ready;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			hv[i] = (phase_q == rbv_pkg::PH_HEADER && pos_q[3:0] == 4'(i)) ? b : hdr_q[i];
		end
	end

	assign f_first  = {hv[7], hv[6], hv[5], hv[4]};
	assign f_vc     = {hv[9], hv[8]};
	assign f_an     = {hv[11], hv[10]};
	assign f_rvc    = {hv[13], hv[12]};
	assign f_rc     = {hv[15], hv[14]};
	assign amin     = ({7'd0, anch_q} < exp_rec_q) ? {7'd0, anch_q} : exp_rec_q;
	assign rc_prod  = f_rc * f_rvc;
	assign rc_hi    = {1'b0, rc_prod} + {17'd0, f_rvc};
	assign len_full = {b, len_q};
	assign ent_full = {b, ent_q};
	assign grp_inc  = grp_q + 16'd1;

	always_comb begin
		phase_n    = phase_q;
		pos_n      = pos_q;
		crc_n      = crc_q;
		len_n      = len_q;
		sub_n      = sub_q;
		rec_cnt_n  = rec_cnt_q;
		sum_n      = sum_q;
		rd_idx_n   = rd_idx_q;
		err_n      = err_q;
		ent_n      = ent_q;
		mis_n      = mis_q;
		hdr_full_n = hdr_full_q;
		grp_n      = grp_q;
		wr_idx_n   = wr_idx_q;
		te_n       = te_q;
		mem_we     = 1'b0;
		emit_rec   = 1'b0;
		emit_st    = 1'b0;
		st         = rbv_pkg::ST_OK;
		got        = '0;
		if (take && item.op == rbv_pkg::OP_DESC) begin
			phase_n    = rbv_pkg::PH_HEADER;
			pos_n      = '0;
			crc_n      = 32'hffff_ffff;
			len_n      = '0;
			sub_n      = '0;
			rec_cnt_n  = '0;
			sum_n      = '0;
			rd_idx_n   = '0;
			err_n      = '0;
			ent_n      = '0;
			mis_n      = 1'b0;
			hdr_full_n = 1'b0;
			grp_n      = '0;
			wr_idx_n   = '0;
		end else if (take_byte) begin
			crc_n = rbv_pkg::crc_byte(crc_q, b);
			pos_n = (pos_q == rbv_pkg::POS_CAP) ? pos_q : pos_q + 41'd1;
			case (phase_q)
				rbv_pkg::PH_HEADER: begin
					if (pos_q == 41'd15) begin
						hdr_full_n = 1'b1;
						te_n = 41'd16 + 41'({f_vc, 1'b0}) + 41'(f_vc) + 41'({f_rc, 2'b00});
						if ({hv[3], hv[2], hv[1], hv[0]} != rbv_pkg::BLK_MAGIC
								|| f_first != exp_first_q || f_vc != exp_rec_q
								|| f_an != amin || f_rvc != intv_q || f_rvc == 16'd0) begin
							phase_n = rbv_pkg::PH_DRAIN;
							err_n   = (err_q == rbv_pkg::ST_OK) ? rbv_pkg::ST_HEADER : err_q;
						end else if (f_vc == 16'd0 || !(rc_prod < {16'd0, f_vc})
								|| !({17'd0, f_vc} <= rc_hi)) begin
							phase_n = rbv_pkg::PH_DRAIN;
							err_n   = (err_q == rbv_pkg::ST_OK) ? rbv_pkg::ST_RCOUNT : err_q;
						end else if ({1'b0, f_rc} > 17'(MAX_RESTARTS)) begin
							phase_n = rbv_pkg::PH_DRAIN;
							err_n   = (err_q == rbv_pkg::ST_OK) ? rbv_pkg::ST_CAPACITY : err_q;
						end else begin
							phase_n = rbv_pkg::PH_LENGTHS;
						end
					end
				end
				rbv_pkg::PH_LENGTHS: begin
					if (sub_q == 2'd2) begin
						sub_n = '0;
						len_n = '0;
						if (len_full == 24'd0) begin
							phase_n = rbv_pkg::PH_DRAIN;
							err_n   = (err_q == rbv_pkg::ST_OK) ? rbv_pkg::ST_LENGTHS : err_q;
						end else begin
							if (rec_cnt_q != 16'd0 && grp_q == 16'd0) begin
								mem_we   = {1'b0, wr_idx_q} < 17'(MAX_RESTARTS);
								wr_idx_n = wr_idx_q + 16'd1;
							end
							emit_rec  = 1'b1;
							sum_n     = sum_q + {16'd0, len_full};
							rec_cnt_n = rec_cnt_q + 16'd1;
							grp_n     = (grp_inc == f_rvc) ? 16'd0 : grp_inc;
							if (rec_cnt_n == f_vc) begin
								phase_n = (f_rc == 16'd0) ? rbv_pkg::PH_PAYLOAD
									: rbv_pkg::PH_RESTARTS;
							end
						end
					end else if (sub_q == 2'd0) begin
						len_n[7:0] = b;
						sub_n = 2'd1;
					end else begin
						len_n[15:8] = b;
						sub_n = 2'd2;
					end
				end
				rbv_pkg::PH_RESTARTS: begin
					case (sub_q)
						2'd0: ent_n[7:0]   = b;
						2'd1: ent_n[15:8]  = b;
						2'd2: ent_n[23:16] = b;
						default: begin
							if ({8'd0, ent_full} != mem_rdata) begin
								mis_n = 1'b1;
							end
							ent_n    = '0;
							rd_idx_n = rd_idx_q + 16'd1;
							if (rd_idx_n == f_rc) begin
								phase_n = rbv_pkg::PH_PAYLOAD;
							end
						end
					endcase
					sub_n = sub_q + 2'd1;
				end
				default: begin
				end
			endcase
			if (item.last_byte) begin
				emit_st = 1'b1;
				got = (pos_n >= te_q) ? pos_n - te_q : 41'd0;
				if (pos_n != {1'b0, exp_cnt_q}) begin
					st = rbv_pkg::ST_SIZE;
				end else if (~crc_n != exp_crc_q) begin
					st = rbv_pkg::ST_CRC;
				end else if (err_n != rbv_pkg::ST_OK) begin
					st = err_n;
				end else if (phase_n == rbv_pkg::PH_HEADER) begin
					st = rbv_pkg::ST_HEADER;
				end else if (phase_n == rbv_pkg::PH_LENGTHS) begin
					st = rbv_pkg::ST_LENGTHS;
				end else if (phase_n == rbv_pkg::PH_RESTARTS) begin
					st = rbv_pkg::ST_RTRUNC;
				end else if (mis_n) begin
					st = rbv_pkg::ST_RMISMAT;
				end else if (got != {1'b0, sum_n} || sum_n[39:32] != 8'd0) begin
					st = rbv_pkg::ST_SPAN;
				end else begin
					st = rbv_pkg::ST_OK;
				end
				phase_n = rbv_pkg::PH_IDLE;
			end
		end
	end

	always_comb begin
		rec_res               = '0;
		rec_res.kind          = rbv_pkg::KIND_RECORD;
		rec_res.record_number = rec_cnt_q;
		rec_res.record_start  = sum_q;
		rec_res.end_flag      = !emit_st;
		st_res                = '0;
		st_res.kind           = rbv_pkg::KIND_STATUS;
		st_res.status         = st;
		st_res.payload_bytes  = (st == rbv_pkg::ST_OK) ? sum_n[31:0] : 32'd0;
		st_res.first_record   = hdr_full_n ? f_first : 32'd0;
		st_res.anchor_count   = hdr_full_n ? f_an : 16'd0;
		st_res.end_flag       = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= rbv_pkg::PH_IDLE;
			pos_q      <= '0;
			crc_q      <= 32'hffff_ffff;
			exp_cnt_q  <= '0;
			exp_crc_q  <= '0;
			exp_first_q <= '0;
			exp_rec_q  <= '0;
			len_q      <= '0;
			sub_q      <= '0;
			rec_cnt_q  <= '0;
			sum_q      <= '0;
			rd_idx_q   <= '0;
			err_q      <= '0;
			ent_q      <= '0;
			mis_q      <= 1'b0;
			hdr_full_q <= 1'b0;
			grp_q      <= '0;
			wr_idx_q   <= '0;
			te_q       <= '0;
			anch_q     <= 9'd1;
			intv_q     <= 16'd1;
			v0_q       <= 1'b0;
			v1_q       <= 1'b0;
		end else begin
			phase_q    <= phase_n;
			pos_q      <= pos_n;
			crc_q      <= crc_n;
			len_q      <= len_n;
			sub_q      <= sub_n;
			rec_cnt_q  <= rec_cnt_n;
			sum_q      <= sum_n;
			rd_idx_q   <= rd_idx_n;
			err_q      <= err_n;
			ent_q      <= ent_n;
			mis_q      <= mis_n;
			hdr_full_q <= hdr_full_n;
			grp_q      <= grp_n;
			wr_idx_q   <= wr_idx_n;
			te_q       <= te_n;
			if (take && item.op == rbv_pkg::OP_DESC) begin
				exp_cnt_q   <= item.expected_byte_count;
				exp_crc_q   <= item.expected_crc;
				exp_first_q <= item.expected_first_record;
				exp_rec_q   <= item.expected_record_count;
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					rbv_pkg::CFG_ANCHOR_LIMIT:     anch_q <= cfg_data[8:0];
					rbv_pkg::CFG_RESTART_INTERVAL: intv_q <= cfg_data;
					default: begin
					end
				endcase
			end
			if (pop) begin
				if (v0_q) begin
					v0_q <= 1'b0;
				end else begin
					v1_q <= 1'b0;
				end
			end
			if (emit_rec) begin
				v0_q <= 1'b1;
			end
			if (emit_st) begin
				v1_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take_byte && phase_q == rbv_pkg::PH_HEADER) begin
			hdr_q[pos_q[3:0]] <= b;
		end
		if (emit_rec) begin
			slot0_q <= rec_res;
		end
		if (emit_st) begin
			slot1_q <= st_res;
		end
	end

	rbv_prefix_ram #(
		.DEPTH(MAX_RESTARTS),
		.AW   (AW)
	) u_prefix_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(wr_idx_q[AW-1:0]),
		.wdata(sum_q),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(mem_rdata)
	);

`ifndef SYNTHESIS
	a_desc_opens: assert property (@(posedge clk) disable iff (!arst_n)
		(take && item.op == rbv_pkg::OP_DESC) |=> phase_q == rbv_pkg::PH_HEADER)
		else $error("descriptor did not open a block");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v0_q && v1_q) |-> !item_ready)
		else $error("item taken with both result slots full");
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(take_byte && item.last_byte) |=> (phase_q == rbv_pkg::PH_IDLE && v1_q))
		else $error("last byte did not close the block with a status");
	a_rec_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == rbv_pkg::PH_LENGTHS) |-> rec_cnt_q < {hdr_q[9], hdr_q[8]})
		else $error("record counter passed the header record count");
`endif

endmodule

// File: test/record_block_validator_tb.sv
// testbench for record_block_validator: builds length-prefixed record blocks, streams them
// with random sender gaps and receiver stalls, and checks every result against a predictor
// depends on rbv_pkg and the record_block_validator rtl
module record_block_validator_tb;

	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 750;
	localparam int PREF_DEPTH = 4096;

	typedef enum int {
		F_NONE, F_SIZE, F_SIZEMAX, F_CRC, F_MAGIC, F_INTZERO, F_RCOUNT, F_CAP, F_ZEROLEN,
		F_TRUNC_HDR, F_TRUNC_LEN, F_TRUNC_RST, F_MISMATCH, F_SPAN, F_BIGLEN, F_ABORT
	} flaw_t;

	typedef struct {
		int          n;
		flaw_t       flaw;
		logic        typed;
		logic [3:0]  st;
	} row_t;

	typedef struct {
		rbv_pkg::item_t it;
		logic        typed;
		logic [3:0]  st;
	} stim_t;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     item_valid = 1'b0;
	logic     item_ready;
	rbv_pkg::item_t    item = '0;
	logic     result_valid;
	logic     result_ready = 1'b0;
	rbv_pkg::result_t  result;
	logic     cfg_valid = 1'b0;
	logic     cfg_ready;
	logic     cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	record_block_validator DUT (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	logic [8:0]  lim_q = 9'd1;
	logic [15:0] intv_q = 16'd1;
	rbv_pkg::phase_t ph = rbv_pkg::PH_IDLE;
	logic [40:0] pos = '0;
	logic [31:0] crc_q = '1;
	logic [7:0]  hdr [16];
	logic [39:0] d_count = '0;
	logic [31:0] d_crc = '0;
	logic [31:0] d_first = '0;
	logic [15:0] d_recs = '0;
	logic [23:0] len_asm = '0;
	logic [15:0] rec_cnt = '0;
	logic [39:0] run_sum = '0;
	logic [39:0] prefix_mem [PREF_DEPTH];
	logic [15:0] rd_idx = '0;
	logic [3:0]  first_err = '0;
	logic [31:0] ent_asm = '0;
	int          sub_cnt = 0;
	logic        mism = 1'b0;
	logic        hdr_full = 1'b0;

	rbv_pkg::result_t expected_results [$];
	stim_t   stim_q [$];
	stim_t   cur_stim;
	logic [7:0] blk [$];

	int errors = 0;
	int checked = 0;
	int blocks = 0;
	int pushed_items = 0;
	int cycles = 0;
	int gap = 0;
	int burst = 0;
	int stall_mode = 0;
	int stall_len = 0;

	function automatic logic [31:0] crc_update(logic [31:0] c, logic [7:0] b);
		c = c ^ {24'd0, b};
		repeat (8) c = {1'b0, c[31:1]} ^ ({32{c[0]}} & rbv_pkg::CRC_POLY);
		return c;
	endfunction

	function automatic logic [31:0] hf(int off, int nb);
		logic [31:0] v;
		v = '0;
		for (int i = 0; i < nb; i++) v |= 32'(hdr[(off + i) & 15]) << (8 * i);
		return v;
	endfunction

	task automatic set_err(logic [3:0] code);
		if (first_err == rbv_pkg::ST_OK) first_err = code;
		ph = rbv_pkg::PH_DRAIN;
	endtask

	task automatic check_hdr();
		logic [31:0] vc, an, rvc, rc, amin, groups;
		vc = hf(8, 2);
		an = hf(10, 2);
		rvc = hf(12, 2);
		rc = hf(14, 2);
		amin = (32'(lim_q) < 32'(d_recs)) ? 32'(lim_q) : 32'(d_recs);
		hdr_full = 1'b1;
		if (hf(0, 4) != rbv_pkg::BLK_MAGIC || hf(4, 4) != d_first || vc != 32'(d_recs) ||
				an != amin || rvc != 32'(intv_q) || rvc == 0) begin
			set_err(rbv_pkg::ST_HEADER);
		end else if (vc == 0) begin
			set_err(rbv_pkg::ST_RCOUNT);
		end else begin
			groups = (vc + rvc - 1) / rvc;
			if (rc != groups - 1) set_err(rbv_pkg::ST_RCOUNT);
			else if (rc > PREF_DEPTH) set_err(rbv_pkg::ST_CAPACITY);
			else ph = rbv_pkg::PH_LENGTHS;
		end
	endtask

	task automatic predict_item(stim_t s);
		rbv_pkg::item_t it;
		logic [40:0] p, tend, got;
		logic [23:0] len;
		logic [31:0] rvc, k;
		logic [39:0] want;
		logic [3:0] st;
		rbv_pkg::result_t r;
		rbv_pkg::result_t outs [$];
		it = s.it;
		if (it.op == rbv_pkg::OP_DESC) begin
			d_count = it.expected_byte_count;
			d_crc = it.expected_crc;
			d_first = it.expected_first_record;
			d_recs = it.expected_record_count;
			ph = rbv_pkg::PH_HEADER;
			pos = '0;
			crc_q = '1;
			foreach (hdr[i]) hdr[i] = '0;
			len_asm = '0;
			rec_cnt = '0;
			run_sum = '0;
			rd_idx = '0;
			first_err = rbv_pkg::ST_OK;
			ent_asm = '0;
			sub_cnt = 0;
			mism = 1'b0;
			hdr_full = 1'b0;
			return;
		end
		if (ph == rbv_pkg::PH_IDLE) return;
		crc_q = crc_update(crc_q, it.data_byte);
		p = pos;
		if (pos < rbv_pkg::POS_CAP) pos = pos + 1;
		case (ph)
			rbv_pkg::PH_HEADER: begin
				hdr[p[3:0]] = it.data_byte;
				if (p == 15) check_hdr();
			end
			rbv_pkg::PH_LENGTHS: begin
				len_asm |= 24'(it.data_byte) << (8 * sub_cnt);
				sub_cnt++;
				if (sub_cnt == 3) begin
					len = len_asm;
					rvc = hf(12, 2);
					sub_cnt = 0;
					len_asm = '0;
					if (len == 0) begin
						set_err(rbv_pkg::ST_LENGTHS);
					end else begin
						if (rec_cnt != 0 && rvc != 0 && (32'(rec_cnt) % rvc) == 0) begin
							k = 32'(rec_cnt) / rvc - 1;
							if (k < PREF_DEPTH) prefix_mem[k] = run_sum;
						end
						r = '0;
						r.kind = rbv_pkg::KIND_RECORD;
						r.record_number = rec_cnt;
						r.record_start = run_sum;
						outs = {outs, r};
						run_sum = run_sum + 40'(len);
						rec_cnt = rec_cnt + 1;
						if (32'(rec_cnt) == hf(8, 2))
							ph = (hf(14, 2) == 0) ? rbv_pkg::PH_PAYLOAD : rbv_pkg::PH_RESTARTS;
					end
				end
			end
			rbv_pkg::PH_RESTARTS: begin
				ent_asm |= 32'(it.data_byte) << (8 * sub_cnt);
				sub_cnt++;
				if (sub_cnt == 4) begin
					want = (rd_idx < PREF_DEPTH) ? prefix_mem[rd_idx] : '0;
					if (40'(ent_asm) != want) mism = 1'b1;
					sub_cnt = 0;
					ent_asm = '0;
					rd_idx = rd_idx + 1;
					if (32'(rd_idx) == hf(14, 2)) ph = rbv_pkg::PH_PAYLOAD;
				end
			end
			default: ;
		endcase
		if (it.last_byte) begin
			r = '0;
			r.kind = rbv_pkg::KIND_STATUS;
			if (pos != 41'(d_count)) st = rbv_pkg::ST_SIZE;
			else if (~crc_q != d_crc) st = rbv_pkg::ST_CRC;
			else if (first_err != rbv_pkg::ST_OK) st = first_err;
			else if (ph == rbv_pkg::PH_HEADER) st = rbv_pkg::ST_HEADER;
			else if (ph == rbv_pkg::PH_LENGTHS) st = rbv_pkg::ST_LENGTHS;
			else if (ph == rbv_pkg::PH_RESTARTS) st = rbv_pkg::ST_RTRUNC;
			else if (mism) st = rbv_pkg::ST_RMISMAT;
			else begin
				tend = 41'd16 + 41'd3 * 41'(hf(8, 2)) + 41'd4 * 41'(hf(14, 2));
				got = (pos >= tend) ? pos - tend : '0;
				if (got != 41'(run_sum) || run_sum > 40'hffff_ffff) begin
					st = rbv_pkg::ST_SPAN;
				end else begin
					st = rbv_pkg::ST_OK;
					r.payload_bytes = run_sum[31:0];
				end
			end
			r.status = st;
			r.first_record = hdr_full ? hf(4, 4) : '0;
			r.anchor_count = hdr_full ? 16'(hf(10, 2)) : '0;
			outs = {outs, r};
			ph = rbv_pkg::PH_IDLE;
			if (s.typed && st != s.st) begin
				$display("%0t status mismatch in directed row: expected %0d actual %0d",
					$time, s.st, st);
				errors++;
			end
		end
		if (outs.size() > 0) outs[outs.size() - 1].end_flag = 1'b1;
		foreach (outs[i]) expected_results = {expected_results, outs[i]};
	endtask

	// sender: bursts with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (item_valid && item_ready) predict_item(cur_stim);
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == rbv_pkg::CFG_ANCHOR_LIMIT) lim_q <= cfg_data[8:0];
				else intv_q <= cfg_data;
			end
			if (!item_valid || item_ready) begin
				if (gap > 0 || stim_q.size() == 0) begin
					item_valid <= 1'b0;
					if (gap > 0) gap--;
				end else begin
					cur_stim = stim_q.pop_front();
					item <= cur_stim.it;
					item_valid <= 1'b1;
					if (burst == 0) begin
						burst = $urandom_range(1, 24);
						gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
					end else begin
						burst--;
					end
				end
			end
		end
	end

	// receiver: stall pattern of its own
	always @(posedge clk) begin
		if (arst_n) begin
			if (stall_len == 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_len = $urandom_range(5, 60);
			end else begin
				stall_len--;
			end
			case (stall_mode)
				0: result_ready <= 1'b1;
				1: result_ready <= ($urandom_range(0, 1) == 1);
				2: result_ready <= (stall_len % 7 == 0);
				default: result_ready <= ($urandom_range(0, 4) != 0);
			endcase
			if (result_valid && result_ready) begin
				checked++;
				if (expected_results.size() == 0) begin
					$display("%0t unexpected result: actual %p", $time, result);
					errors++;
				end else begin
					rbv_pkg::result_t e;
					e = expected_results.pop_front();
					if (result !== e) begin
						$display("%0t result mismatch: expected %p actual %p", $time, e, result);
						errors++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	task automatic put_le(logic [31:0] v, int nb);
		for (int i = 0; i < nb; i++) blk = {blk, v[8 * i +: 8]};
	endtask

	task automatic push_item(rbv_pkg::item_t it, logic typed, logic [3:0] st);
		stim_t s;
		s.it = it;
		s.typed = typed;
		s.st = st;
		stim_q = {stim_q, s};
		pushed_items++;
	endtask

	task automatic build_block(int n, flaw_t flaw, logic typed, logic [3:0] st);
		logic [31:0] first, rvc, rc, anchors, c, sum;
		logic [23:0] lens [$];
		int keep, tstart;
		rbv_pkg::item_t it;
		blk.delete();
		first = $urandom;
		rvc = 32'(intv_q);
		if (flaw == F_INTZERO) rvc = 0;
		rc = (flaw == F_INTZERO) ? 0 : (n + intv_q - 1) / intv_q - 1;
		if (flaw == F_RCOUNT) rc = rc + 1;
		anchors = (32'(lim_q) < n) ? 32'(lim_q) : n;
		put_le((flaw == F_MAGIC) ? rbv_pkg::BLK_MAGIC ^ 32'h0100 : rbv_pkg::BLK_MAGIC, 4);
		put_le(first, 4);
		put_le(n, 2);
		put_le(anchors, 2);
		put_le(rvc, 2);
		put_le(rc, 2);
		if (flaw != F_CAP) begin
			for (int i = 0; i < n; i++) lens = {lens, 24'($urandom_range(1, 6))};
			if (flaw == F_ZEROLEN) lens[n / 2] = '0;
			if (flaw == F_BIGLEN) lens[n - 1] = 24'hff_ffff;
			foreach (lens[i]) put_le(32'(lens[i]), 3);
			tstart = blk.size();
			sum = '0;
			for (int i = 0; i < n; i++) begin
				if (intv_q != 0 && i != 0 && i % intv_q == 0 && i / intv_q - 1 < rc)
					put_le(sum, 4);
				sum = sum + 32'(lens[i]);
			end
			if (flaw == F_MISMATCH && blk.size() > tstart)
				blk[tstart] = blk[tstart] ^ 8'(1 << $urandom_range(0, 7));
			if (flaw != F_BIGLEN) repeat (sum) blk = {blk, 8'($urandom)};
			if (flaw == F_SPAN) blk = {blk, 8'($urandom)};
			keep = blk.size();
			if (flaw == F_TRUNC_HDR) keep = $urandom_range(1, 15);
			if (flaw == F_TRUNC_LEN) keep = 16 + $urandom_range(1, 3 * n - 1);
			if (flaw == F_TRUNC_RST) keep = tstart + 2;
			if (flaw == F_ABORT) keep = $urandom_range(1, blk.size());
			while (blk.size() > keep) void'(blk.pop_back());
		end
		c = '1;
		foreach (blk[i]) c = crc_update(c, blk[i]);
		it = '0;
		it.op = rbv_pkg::OP_DESC;
		it.data_byte = 8'($urandom);
		it.last_byte = 1'($urandom);
		it.expected_byte_count = 40'(blk.size());
		if (flaw == F_SIZE) it.expected_byte_count = it.expected_byte_count + 1;
		if (flaw == F_SIZEMAX) it.expected_byte_count = '1;
		it.expected_crc = ~c;
		if (flaw == F_CRC) it.expected_crc = it.expected_crc ^ (32'd1 << $urandom_range(0, 31));
		it.expected_first_record = first;
		it.expected_record_count = 16'(n);
		push_item(it, 1'b0, rbv_pkg::ST_OK);
		foreach (blk[i]) begin
			it = '0;
			it.op = rbv_pkg::OP_BYTE;
			it.data_byte = blk[i];
			it.last_byte = (i == blk.size() - 1) && (flaw != F_ABORT);
			it.expected_byte_count = 40'({$urandom, $urandom});
			it.expected_crc = $urandom;
			it.expected_first_record = $urandom;
			it.expected_record_count = 16'($urandom);
			push_item(it, typed && it.last_byte, st);
		end
		blocks++;
	endtask

	task automatic idle_bytes(int cnt);
		rbv_pkg::item_t it;
		repeat (cnt) begin
			it = {2'($urandom), $urandom, $urandom, $urandom, $urandom};
			it.op = rbv_pkg::OP_BYTE;
			push_item(it, 1'b0, rbv_pkg::ST_OK);
			pushed_items--;
		end
	endtask

	task automatic random_junk();
		rbv_pkg::item_t it;
		int cnt;
		it = {2'($urandom), $urandom, $urandom, $urandom, $urandom};
		it.op = rbv_pkg::OP_DESC;
		push_item(it, 1'b0, rbv_pkg::ST_OK);
		cnt = $urandom_range(3, 24);
		for (int i = 0; i < cnt; i++) begin
			it = {2'($urandom), $urandom, $urandom, $urandom, $urandom};
			it.op = rbv_pkg::OP_BYTE;
			it.last_byte = (i == cnt - 1);
			push_item(it, 1'b0, rbv_pkg::ST_OK);
		end
	endtask

	task automatic drain();
		while (stim_q.size() != 0 || item_valid) @(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	row_t rows [] = '{
		'{2, F_NONE, 1'b1, rbv_pkg::ST_OK},
		'{5, F_NONE, 1'b1, rbv_pkg::ST_OK},
		'{3, F_SIZE, 1'b1, rbv_pkg::ST_SIZE},
		'{3, F_SIZEMAX, 1'b1, rbv_pkg::ST_SIZE},
		'{3, F_CRC, 1'b1, rbv_pkg::ST_CRC},
		'{3, F_MAGIC, 1'b1, rbv_pkg::ST_HEADER},
		'{3, F_INTZERO, 1'b1, rbv_pkg::ST_HEADER},
		'{4, F_RCOUNT, 1'b1, rbv_pkg::ST_RCOUNT},
		'{5000, F_CAP, 1'b1, rbv_pkg::ST_CAPACITY},
		'{65535, F_CAP, 1'b1, rbv_pkg::ST_CAPACITY},
		'{4, F_ZEROLEN, 1'b1, rbv_pkg::ST_LENGTHS},
		'{3, F_TRUNC_HDR, 1'b1, rbv_pkg::ST_HEADER},
		'{4, F_TRUNC_LEN, 1'b1, rbv_pkg::ST_LENGTHS},
		'{5, F_TRUNC_RST, 1'b1, rbv_pkg::ST_RTRUNC},
		'{5, F_MISMATCH, 1'b1, rbv_pkg::ST_RMISMAT},
		'{3, F_SPAN, 1'b1, rbv_pkg::ST_SPAN},
		'{2, F_BIGLEN, 1'b1, rbv_pkg::ST_SPAN},
		'{4, F_ABORT, 1'b0, rbv_pkg::ST_OK},
		'{3, F_NONE, 1'b0, rbv_pkg::ST_OK}
	};

	initial begin
		flaw_t pick;
		int lim_sel, int_sel;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_reg(rbv_pkg::CFG_ANCHOR_LIMIT, 16'd3);
		write_reg(rbv_pkg::CFG_RESTART_INTERVAL, 16'd1);
		idle_bytes(3);
		foreach (rows[i]) build_block(rows[i].n, rows[i].flaw, rows[i].typed, rows[i].st);
		drain();

		while (pushed_items < RANDOM_ITEMS) begin
			lim_sel = $urandom_range(0, 2);
			int_sel = $urandom_range(0, 3);
			write_reg(rbv_pkg::CFG_ANCHOR_LIMIT, (lim_sel == 0) ? 16'd1 :
				(lim_sel == 1) ? 16'd256 : 16'($urandom_range(1, 256)));
			write_reg(rbv_pkg::CFG_RESTART_INTERVAL, (int_sel == 0) ? 16'd1 :
				(int_sel == 1) ? 16'd65535 : 16'($urandom_range(2, 4)));
			repeat (4) begin
				case ($urandom_range(0, 19))
					0: idle_bytes($urandom_range(1, 4));
					1: random_junk();
					2: build_block($urandom_range(1, 10), F_ABORT, 1'b0, rbv_pkg::ST_OK);
					default: begin
						pick = F_NONE;
						if ($urandom_range(0, 9) < 3) begin
							case ($urandom_range(0, 9))
								0: pick = F_SIZE;
								1: pick = F_CRC;
								2: pick = F_MAGIC;
								3: pick = F_RCOUNT;
								4: pick = F_ZEROLEN;
								5: pick = F_TRUNC_HDR;
								6: pick = F_TRUNC_LEN;
								7: pick = F_SPAN;
								8: pick = F_MISMATCH;
								default: pick = F_BIGLEN;
							endcase
						end
						build_block($urandom_range(1, 12), pick, 1'b0, rbv_pkg::ST_OK);
					end
				endcase
			end
			// close any open block before the next register writes
			random_junk();
			drain();
		end

		$display("covered %0d blocks with directed and random flaws, %0d results checked",
			blocks, checked);
		$display("receiver stall patterns and sender gaps varied throughout, %0d mismatches",
			errors);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule

// File: sim.f
hw/rtl/rbv_pkg.sv
hw/rtl/rbv_prefix_ram.sv
hw/rtl/record_block_validator.sv
test/record_block_validator_tb.sv
